@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the stopwatch table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define NST_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property at every clock edge, reset included.
`define NST_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/core/nst_pkg.sv @@
// Package with the sizes, codes and constants of the stopwatch table.
package nst_pkg;

   // Table geometry
   localparam int SLOT_COUNT = 16;
   localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

   // Field widths
   localparam int OP_W     = 2;
   localparam int KEY_W    = 32;
   localparam int TICK_W   = 64;
   localparam int RATE_W   = 16;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 4;
   localparam int FRAME_W  = 22;

   // Operation codes
   localparam logic [OP_W-1:0] OP_START  = 2'd0;
   localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
   localparam logic [OP_W-1:0] OP_TAKE   = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   // Tick rate after reset (60.75 ticks per microsecond, Q8.8)
   localparam logic [RATE_W-1:0] RATE_RESET = 16'd15552;

   // Divider: 32-bit tick delta shifted by the 8 rate fraction bits
   localparam int DELTA_W   = 32;
   localparam int DVD_W     = DELTA_W + 8;
   localparam int DIV_STEPS = DVD_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   // Microseconds are kept modulo one second
   localparam int USEC_W = 20;
   localparam logic [USEC_W:0] USEC_MOD = 21'd1000000;

   // frames = floor(usec * 12288 / 3125), as usec * ceil(12288 * 2^32 / 3125) >> 32
   localparam int MUL_W   = 34;
   localparam int MUL_SH  = 32;
   localparam int PROD_W  = USEC_W + MUL_W;
   localparam logic [MUL_W-1:0] FRAME_MUL = 34'd16888498603;

   // One word of the key and start memory
   typedef struct packed {
      logic [TICK_W-1:0] start;
      logic [KEY_W-1:0]  key;
   } ks_word_type;

endpackage

@@ rtl/core/nst_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module nst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/named_stopwatch_table.sv @@
// Top level of the named stopwatch table: slot scan, tick conversion and stream ports.
//
// Sixteen stopwatches named by a 32-bit key, held in two RAMs (key and start time, stored
// elapsed frames) with per-slot used and elapsed-valid flops cleared at reset, so no
// clearing pass is needed and the block takes a word right after reset. One word is
// worked on at a time. The key scan reads one slot at a time (RAM read, then compare)
// and stops at the first hit; a miss or a new start visits all 16 slots. An update that
// hits then runs a bit-serial divider by the tick rate, which produces one quotient bit
// per cycle while the microsecond count is reduced modulo one second on the fly, then
// one multiply turns microseconds into frames. The result word sits in an output
// register, so the next word is taken while it waits. tick_rate_q8 may be written only
// while no word is in flight.
`include "assert_macros.svh"

module named_stopwatch_table (
   input  logic         clock,
   input  logic         reset,
   // Configuration: tick_rate_q8
   input  logic         csr_we,
   input  logic [15:0]  csr_wdata,
   // Request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,    // key_id [31:0], now_ticks [95:32]
   input  logic [1:0]   req_tuser,    // operation [1:0]
   // Response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,    // slot [3:0], elapsed_frames [25:4], zero [31:26]
   output logic [1:0]   rsp_tuser     // status [1:0]
);

   localparam int IDX_W   = nst_pkg::IDX_W;
   localparam int KS_W    = $bits(nst_pkg::ks_word_type);
   localparam int FRAME_W = nst_pkg::FRAME_W;

   // Sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_READ   = 3'd1;
   localparam logic [2:0] ST_CMP    = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_MUL    = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;
   localparam logic [2:0] ST_RESP   = 3'd6;

   // Control registers
   logic [2:0]                        state_ff, state_in;
   logic [nst_pkg::SLOT_COUNT-1:0]    used_ff, used_in;
   logic [nst_pkg::SLOT_COUNT-1:0]    el_valid_ff, el_valid_in;
   logic [nst_pkg::RATE_W-1:0]        rate_ff, rate_in;
   logic                              found_ff, found_in;
   logic                              free_found_ff, free_found_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [nst_pkg::STEP_W-1:0]        step_ff, step_in;

   // Payload registers
   logic [nst_pkg::OP_W-1:0]          op_ff, op_in;
   logic [nst_pkg::KEY_W-1:0]         key_ff, key_in;
   logic [nst_pkg::TICK_W-1:0]        now_ff, now_in;
   logic [IDX_W-1:0]                  idx_ff, idx_in;
   logic [IDX_W-1:0]                  hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]                  free_idx_ff, free_idx_in;
   logic [FRAME_W-1:0]                elapsed_ff, elapsed_in;
   logic [nst_pkg::DVD_W-1:0]         dvd_ff, dvd_in;
   logic [nst_pkg::RATE_W-1:0]        rem_ff, rem_in;
   logic [nst_pkg::USEC_W-1:0]        usec_ff, usec_in;
   logic [nst_pkg::PROD_W-1:0]        prod_ff, prod_in;
   logic [nst_pkg::STATUS_W-1:0]      res_status_ff, res_status_in;
   logic [nst_pkg::SLOT_W-1:0]        res_slot_ff, res_slot_in;
   logic [FRAME_W-1:0]                res_frames_ff, res_frames_in;
   logic [nst_pkg::STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [nst_pkg::SLOT_W-1:0]        rsp_slot_ff, rsp_slot_in;
   logic [FRAME_W-1:0]                rsp_frames_ff, rsp_frames_in;

   // Memory ports
   logic                              ks_we;
   logic [IDX_W-1:0]                  ks_waddr;
   nst_pkg::ks_word_type              ks_wdata;
   nst_pkg::ks_word_type              ks_rdata;
   logic                              el_we;
   logic [IDX_W-1:0]                  el_waddr;
   logic [FRAME_W-1:0]                el_wdata;
   logic [FRAME_W-1:0]                el_rdata;

   // Working signals
   logic                              hit;
   logic [nst_pkg::DELTA_W-1:0]       delta;
   logic [nst_pkg::RATE_W:0]          rate_eff;
   logic [nst_pkg::RATE_W:0]          rem_shift;
   logic                              qbit;
   logic [nst_pkg::USEC_W:0]          usec_shift;
   logic [IDX_W-1:0]                  sel_idx;
   logic [IDX_W+3:0]                  slot_ext;

   // Key and start time memory
   nst_ram #(
      .WIDTH (KS_W),
      .DEPTH (nst_pkg::SLOT_COUNT)
   ) u_ks_ram (
      .clock   (clock),
      .wr_en   (ks_we),
      .wr_addr (ks_waddr),
      .wr_data (ks_wdata),
      .rd_addr (idx_ff),
      .rd_data (ks_rdata)
   );

   // Stored elapsed frames memory
   nst_ram #(
      .WIDTH (FRAME_W),
      .DEPTH (nst_pkg::SLOT_COUNT)
   ) u_el_ram (
      .clock   (clock),
      .wr_en   (el_we),
      .wr_addr (el_waddr),
      .wr_data (el_wdata),
      .rd_addr (idx_ff),
      .rd_data (el_rdata)
   );

   // Compare, divide and reduce terms
   assign hit        = used_ff[idx_ff] && (ks_rdata.key == key_ff);
   assign delta      = now_ff[nst_pkg::DELTA_W-1:0] - ks_rdata.start[nst_pkg::DELTA_W-1:0];
   assign rate_eff   = {1'b0, (rate_ff == '0) ? nst_pkg::RATE_W'(1) : rate_ff};
   assign rem_shift  = {rem_ff, dvd_ff[nst_pkg::DVD_W-1]};
   assign qbit       = (rem_shift >= rate_eff);
   assign usec_shift = {usec_ff, qbit};
   assign sel_idx    = found_ff ? hit_idx_ff : free_idx_ff;
   assign slot_ext   = {4'b0000, sel_idx};

   // Sequencer next state
   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      el_valid_in   = el_valid_ff;
      rate_in       = rate_ff;
      found_in      = found_ff;
      free_found_in = free_found_ff;
      rsp_valid_in  = rsp_valid_ff;
      step_in       = step_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      now_in        = now_ff;
      idx_in        = idx_ff;
      hit_idx_in    = hit_idx_ff;
      free_idx_in   = free_idx_ff;
      elapsed_in    = elapsed_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;
      usec_in       = usec_ff;
      prod_in       = prod_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_frames_in = res_frames_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_frames_in = rsp_frames_ff;
      ks_we         = 1'b0;
      ks_waddr      = sel_idx;
      ks_wdata      = '{start: now_ff, key: key_ff};
      el_we         = 1'b0;
      el_waddr      = hit_idx_ff;
      el_wdata      = prod_ff[nst_pkg::PROD_W-1:nst_pkg::MUL_SH];

      // Take the tick rate
      if (csr_we) begin
         rate_in = csr_wdata;
      end

      // Drop the response word once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in         = req_tuser;
               key_in        = req_tdata[31:0];
               now_in        = req_tdata[95:32];
               idx_in        = '0;
               hit_idx_in    = '0;
               free_idx_in   = '0;
               found_in      = 1'b0;
               free_found_in = 1'b0;
               elapsed_in    = '0;
               if (req_tuser == nst_pkg::OP_START || req_tuser == nst_pkg::OP_UPDATE ||
                   req_tuser == nst_pkg::OP_TAKE) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            // Record a key hit along with its stored frames
            if (hit) begin
               found_in   = 1'b1;
               hit_idx_in = idx_ff;
               elapsed_in = el_valid_ff[idx_ff] ? el_rdata : '0;
            end
            // Remember the lowest free slot
            if (!used_ff[idx_ff] && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = idx_ff;
            end
            if (hit || idx_ff == nst_pkg::LAST_IDX) begin
               if (hit && op_ff == nst_pkg::OP_UPDATE) begin
                  dvd_in   = {delta, 8'h00};
                  rem_in   = '0;
                  usec_in  = '0;
                  step_in  = '0;
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_FINISH;
               end
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_READ;
            end
         end
         ST_DIV: begin
            // One quotient bit, folded into microseconds modulo one second
            rem_in = qbit ? nst_pkg::RATE_W'(rem_shift - rate_eff)
                          : rem_shift[nst_pkg::RATE_W-1:0];
            dvd_in = {dvd_ff[nst_pkg::DVD_W-2:0], 1'b0};
            usec_in = (usec_shift >= nst_pkg::USEC_MOD)
                    ? nst_pkg::USEC_W'(usec_shift - nst_pkg::USEC_MOD)
                    : usec_shift[nst_pkg::USEC_W-1:0];
            step_in = step_ff + nst_pkg::STEP_W'(1);
            if (step_ff == nst_pkg::STEP_W'(nst_pkg::DIV_STEPS - 1)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = nst_pkg::PROD_W'(usec_ff) * nst_pkg::PROD_W'(nst_pkg::FRAME_MUL);
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            res_status_in = nst_pkg::STATUS_DONE;
            res_slot_in   = '0;
            res_frames_in = '0;
            unique case (op_ff)
               nst_pkg::OP_START: begin
                  if (found_ff || free_found_ff) begin
                     ks_we            = 1'b1;
                     used_in[sel_idx] = 1'b1;
                     res_slot_in      = slot_ext[3:0];
                  end else begin
                     res_status_in = nst_pkg::STATUS_FULL;
                  end
               end
               nst_pkg::OP_UPDATE: begin
                  if (found_ff) begin
                     el_we                   = 1'b1;
                     el_valid_in[hit_idx_ff] = 1'b1;
                     res_slot_in             = slot_ext[3:0];
                  end else begin
                     res_status_in = nst_pkg::STATUS_MISS;
                  end
               end
               nst_pkg::OP_TAKE: begin
                  if (found_ff) begin
                     used_in[hit_idx_ff] = 1'b0;
                     res_slot_in         = slot_ext[3:0];
                     res_frames_in       = elapsed_ff;
                  end else begin
                     res_status_in = nst_pkg::STATUS_MISS;
                  end
               end
               default: begin
                  res_status_in = nst_pkg::STATUS_DONE;
               end
            endcase
            state_in = ST_RESP;
         end
         ST_RESP: begin
            // Load the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_frames_in = res_frames_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_ff       <= '0;
         el_valid_ff   <= '0;
         rate_ff       <= nst_pkg::RATE_RESET;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         step_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         el_valid_ff   <= el_valid_in;
         rate_ff       <= rate_in;
         found_ff      <= found_in;
         free_found_ff <= free_found_in;
         rsp_valid_ff  <= rsp_valid_in;
         step_ff       <= step_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      now_ff        <= now_in;
      idx_ff        <= idx_in;
      hit_idx_ff    <= hit_idx_in;
      free_idx_ff   <= free_idx_in;
      elapsed_ff    <= elapsed_in;
      dvd_ff        <= dvd_in;
      rem_ff        <= rem_in;
      usec_ff       <= usec_in;
      prod_ff       <= prod_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_frames_ff <= res_frames_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_frames_ff <= rsp_frames_in;
   end

   // Ports
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_frames_ff, rsp_slot_ff};
   assign rsp_tuser  = rsp_status_ff;

   // Assertions
   `NST_ASSERT_ALWAYS(a_div_needs_hit,
      (state_ff == ST_DIV) |-> (found_ff && op_ff == nst_pkg::OP_UPDATE),
      "divider running without an update hit")
   `NST_ASSERT(a_full_means_all_used,
      (state_ff == ST_FINISH && op_ff == nst_pkg::OP_START && !found_ff && !free_found_ff)
      |-> (&used_ff),
      "table reported full while a slot is free")
   `NST_ASSERT(a_hit_slot_used,
      (state_ff == ST_FINISH && found_ff) |-> used_ff[hit_idx_ff],
      "key hit on a free slot")
   `NST_ASSERT(a_one_word_in_flight,
      (req_tvalid && req_tready) |=> !req_tready,
      "second request taken while one is in flight")

endmodule

@@ verif/tb_named_stopwatch_table.sv @@
// Self-checking testbench for the named stopwatch table, with a scoreboard and random traffic.
`timescale 1ns / 100ps

module tb_named_stopwatch_table;
   import nst_pkg::*;

   // Operation code with no effect; the package names only the three real ones
   localparam logic [OP_W-1:0] OP_NOP = 2'd3;
   localparam int KEY_POOL = 20;
   localparam int SEGMENT_WORDS = 300;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [FRAME_W-1:0]  frames;
   } stopwatch_answer_type;

   // Predicts the table and compares each response word with the oldest prediction
   class stopwatch_checker;
      logic [RATE_W-1:0]  tick_rate;
      bit                 used [SLOT_COUNT];
      logic [KEY_W-1:0]   keys [SLOT_COUNT];
      logic [TICK_W-1:0]  starts [SLOT_COUNT];
      logic [FRAME_W-1:0] elapsed [SLOT_COUNT];
      stopwatch_answer_type awaited_answers [$];
      int errors;
      int reported;

      function new();
         tick_rate = RATE_RESET;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            used[i] = 1'b0;
            keys[i] = '0;
            starts[i] = '0;
            elapsed[i] = '0;
         end
         errors = 0;
         reported = 0;
      endfunction

      function void set_rate(logic [RATE_W-1:0] rate);
         tick_rate = rate;
      endfunction

      function int pending();
         return awaited_answers.size();
      endfunction

      function int find_key(logic [KEY_W-1:0] key);
         int hit;
         hit = -1;
         for (int i = SLOT_COUNT - 1; i >= 0; i--)
            if (used[i] && keys[i] == key) hit = i;
         return hit;
      endfunction

      function int find_free();
         int hit;
         hit = -1;
         for (int i = SLOT_COUNT - 1; i >= 0; i--)
            if (!used[i]) hit = i;
         return hit;
      endfunction

      // Low 32 bits of the tick delta, to microseconds mod one second, to 60 Hz frames Q6.16
      function logic [FRAME_W-1:0] frames_between(logic [TICK_W-1:0] now,
                                                  logic [TICK_W-1:0] start);
         logic [31:0] delta;
         logic [63:0] usec;
         logic [63:0] rate;
         delta = now[31:0] - start[31:0];
         rate = (tick_rate == '0) ? 64'd1 : 64'(tick_rate);
         usec = ((64'(delta) << 8) / rate) % 64'd1000000;
         return FRAME_W'((usec * 64'd3932160) / 64'd1000000);
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                 logic [TICK_W-1:0] now);
         stopwatch_answer_type ans;
         int s;
         ans.status = STATUS_DONE;
         ans.slot = '0;
         ans.frames = '0;
         case (op)
            OP_START: begin
               s = find_key(key);
               if (s < 0) s = find_free();
               if (s < 0) begin
                  ans.status = STATUS_FULL;
               end else begin
                  used[s] = 1'b1;
                  keys[s] = key;
                  starts[s] = now;
                  ans.slot = SLOT_W'(s);
               end
            end
            OP_UPDATE: begin
               s = find_key(key);
               if (s < 0) begin
                  ans.status = STATUS_MISS;
               end else begin
                  elapsed[s] = frames_between(now, starts[s]);
                  ans.slot = SLOT_W'(s);
               end
            end
            OP_TAKE: begin
               s = find_key(key);
               if (s < 0) begin
                  ans.status = STATUS_MISS;
               end else begin
                  used[s] = 1'b0;
                  ans.frames = elapsed[s];
                  ans.slot = SLOT_W'(s);
               end
            end
            default: ;
         endcase
         awaited_answers.push_back(ans);
      endfunction

      function void check_response(stopwatch_answer_type got);
         stopwatch_answer_type want;
         if (awaited_answers.size() == 0) begin
            errors++;
            if (reported < 10) begin
               reported++;
               $display("unexpected response: status %0d slot %0d frames %0d",
                        got.status, got.slot, got.frames);
            end
            return;
         end
         want = awaited_answers.pop_front();
         if (got.status != want.status || got.slot != want.slot ||
             got.frames != want.frames) begin
            errors++;
            if (reported < 10) begin
               reported++;
               $display("mismatch: expected status %0d slot %0d frames %0d, got %0d %0d %0d",
                        want.status, want.slot, want.frames,
                        got.status, got.slot, got.frames);
            end
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_we = 1'b0;
   logic [RATE_W-1:0]  csr_wdata = '0;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [95:0]        req_tdata = '0;    // key_id [31:0], now_ticks [95:32]
   logic [1:0]         req_tuser = '0;    // operation [1:0]
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [31:0]        rsp_tdata;         // slot [3:0], elapsed_frames [25:4]
   logic [1:0]         rsp_tuser;         // status [1:0]

   int                 send_idle_pct = 0;
   int                 rsp_idle_pct = 0;
   int                 stall_left = 0;
   logic [TICK_W-1:0]  timer = '0;
   logic [KEY_W-1:0]   key_pool [KEY_POOL];
   stopwatch_checker   board = new();

   named_stopwatch_table dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   // Count down a long receiver hold-off
   always @(posedge clock) begin
      if (stall_left > 0) stall_left <= stall_left - 1;
   end

   // Drive ready at the falling edge, idle at random, hold off while a stall runs
   initial begin
      forever begin
         @(negedge clock);
         rsp_tready = (stall_left == 0) && ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   // Check every response word taken
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_response({rsp_tuser, rsp_tdata[3:0], rsp_tdata[25:4]});
   end

   // Offer one request word, idling first at random, and note it once taken
   task automatic send_word(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                            logic [TICK_W-1:0] now);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = op;
      req_tdata = {now, key};
      do @(posedge clock); while (!req_tready);
      board.note_request(op, key, now);
   endtask

   task automatic drop_valid();
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // Wait until every response is back, then let the block settle
   task automatic drain();
      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_rate(logic [RATE_W-1:0] rate);
      @(negedge clock);
      csr_we = 1'b1;
      csr_wdata = rate;
      @(negedge clock);
      csr_we = 1'b0;
      board.set_rate(rate);
   endtask

   // Timer that mostly advances by deltas of random magnitude, sometimes jumps anywhere
   function automatic logic [TICK_W-1:0] next_ticks();
      if ($urandom_range(0, 3) == 0) begin
         timer = {$urandom, $urandom};
      end else begin
         timer = timer + (64'($urandom) >> $urandom_range(0, 31));
      end
      return timer;
   endfunction

   task automatic directed_words();
      send_word(OP_TAKE, 32'h1234_5678, 64'd5);
      send_word(OP_UPDATE, 32'h1234_5678, 64'd7);
      send_word(OP_NOP, 32'h1234_5678, 64'd9);
      send_word(OP_START, 32'h0000_0000, 64'h0);
      send_word(OP_START, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      // Largest possible tick delta
      send_word(OP_UPDATE, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
      send_word(OP_TAKE, 32'h0000_0000, 64'h1);
      // Reuse of a freed slot keeps the stale elapsed value
      send_word(OP_START, 32'h0000_0000, 64'h8000_0000_0000_0000);
      send_word(OP_TAKE, 32'h0000_0000, 64'h8000_0000_0000_0001);
      // Restart of an existing key, then a zero delta
      send_word(OP_START, 32'hFFFF_FFFF, 64'h0123_4567_89AB_CDEF);
      send_word(OP_UPDATE, 32'hFFFF_FFFF, 64'h0123_4567_89AB_CDEF);
      // Fill the table, the last start finds it full
      for (int i = 0; i < SLOT_COUNT; i++)
         send_word(OP_START, key_pool[i], next_ticks());
      drop_valid();
   endtask

   // Mostly start/update/take on a small key pool, some stray keys and no-ops
   task automatic random_words(int count);
      int pick;
      logic [OP_W-1:0] op;
      logic [KEY_W-1:0] key;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) op = OP_START;
         else if (pick < 70) op = OP_UPDATE;
         else if (pick < 95) op = OP_TAKE;
         else op = OP_NOP;
         if ($urandom_range(0, 9) == 0) key = $urandom;
         else key = key_pool[$urandom_range(0, KEY_POOL - 1)];
         send_word(op, key, next_ticks());
      end
      drop_valid();
   endtask

   task automatic run_segment(logic [RATE_W-1:0] rate, int send_pct, int rsp_pct,
                              bit hold_off);
      drain();
      write_rate(rate);
      send_idle_pct = send_pct;
      rsp_idle_pct = rsp_pct;
      if (hold_off) stall_left = 400;
      random_words(SEGMENT_WORDS);
   endtask

   initial begin
      for (int i = 0; i < KEY_POOL; i++) key_pool[i] = $urandom;
      key_pool[KEY_POOL - 2] = 32'h0000_0000;
      key_pool[KEY_POOL - 1] = 32'hFFFF_FFFF;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed words at the reset tick rate, no idling
      directed_words();

      run_segment(16'd1, 15, 67, 1'b0);
      run_segment(16'hFFFF, 15, 67, 1'b0);
      run_segment(16'd0, 67, 15, 1'b0);
      run_segment(RATE_W'($urandom), 67, 15, 1'b0);
      run_segment(RATE_RESET, 0, 0, 1'b1);
      run_segment(RATE_W'($urandom), 0, 0, 1'b0);

      while (board.pending() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (board.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Guard against a hung handshake
   initial begin
      #4_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
